[rtl/core/two_way_hash_set_cache_defines.svh]
// Assertion macros used by the cache top level.
`ifndef TWO_WAY_HASH_SET_CACHE_DEFINES_SVH
`define TWO_WAY_HASH_SET_CACHE_DEFINES_SVH

// Concurrent check, sampled on the rising clock and switched off during reset.
`define TWHSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that a condition never holds.
`define TWHSC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/twhsc_pkg.sv]
`timescale 1ns / 1ps

package twhsc_pkg;

  // Default number of two-slot buckets.
  localparam int unsigned CLUSTERS_DEF = 4096;

  // Field widths.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned OCC_W   = 14;
  localparam int unsigned EVICT_W = 32;

  // Saturation limits of the two counters.
  localparam logic [OCC_W-1:0]   OCC_MAX   = '1;
  localparam logic [EVICT_W-1:0] EVICT_MAX = '1;

  // Command codes; the unused code behaves as a lookup.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_EVAL,
    ST_SWEEP
  } state_e;

  // Write controls for the two slot memories.
  typedef struct packed {
    logic we_first;
    logic we_second;
    logic wipe;
  } mem_ctrl_t;

endpackage

[rtl/core/twhsc_ram.sv]
`timescale 1ns / 1ps

module twhsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             we_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/core/twhsc_bucket.sv]
`timescale 1ns / 1ps

module twhsc_bucket import twhsc_pkg::*; #(
  parameter int unsigned CLUSTERS = CLUSTERS_DEF,
  localparam int unsigned AW      = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [KEY_W-1:0] key_i,
  output logic [AW-1:0]    bucket_o
);

  localparam int unsigned CW = $clog2(CLUSTERS + 1);
  localparam int unsigned PW = 32 + CW;
  localparam int unsigned MW = PW + 1;
  localparam int unsigned BW = MW - 32;
  localparam logic [PW-1:0] CLUS_C = PW'(CLUSTERS);
  localparam logic [BW-1:0] LAST_B = BW'(CLUSTERS - 1);

  logic [PW-1:0] lo_c_q, hi_c_q;
  logic [MW-1:0] mid;
  logic [BW-1:0] bkt_full;

  // First stage: both halves of the key times the bucket count.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_c_q <= PW'(key_i[31:0]) * CLUS_C;
      hi_c_q <= PW'(key_i[63:32]) * CLUS_C;
    end
  end

  // Second stage: combine the partial products and keep the upper word.
  always_comb begin
    mid      = MW'(hi_c_q) + MW'(lo_c_q >> 32);
    bkt_full = mid[MW-1:32];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_full > LAST_B) begin
      bucket_o <= AW'(LAST_B);
    end else begin
      bucket_o <= bkt_full[AW-1:0];
    end
  end

endmodule

[rtl/core/two_way_hash_set_cache.sv]
`timescale 1ns / 1ps
// Channel | Beat marked by     | Ports
// command | start and not busy | command_i key_i
// result  | done_o             | present_o stored_o evicted_o occupied_total_o eviction_total_o
//
// A lookup or insert runs hash multiply, bucket register, memory read, then
// compare and write back; done_o rises as busy falls, and the next beat may
// be taken in that same cycle. A clear zeroes both slot memories one bucket
// a cycle; done_o rises once the last bucket is zeroed. After reset the same
// pass runs with busy high and no result. The receiver cannot stall the result.

module two_way_hash_set_cache import twhsc_pkg::*; #(
  parameter int unsigned CLUSTERS = CLUSTERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               done_o,
  output logic               present_o,
  output logic               stored_o,
  output logic               evicted_o,
  output logic [OCC_W-1:0]   occupied_total_o,
  output logic [EVICT_W-1:0] eviction_total_o
);

  `include "two_way_hash_set_cache_defines.svh"

  localparam int unsigned AW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam logic [AW-1:0] LAST_A = AW'(CLUSTERS - 1);

  state_e state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic report_q, report_d;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [EVICT_W-1:0] evc_q, evc_d;
  logic done_q, done_d;
  logic present_q, stored_q, evicted_q;
  logic present_d, stored_d, evicted_d;

  logic accept;
  logic [AW-1:0] bucket;
  logic [AW-1:0] mem_addr;
  logic [KEY_W-1:0] s0, s1;
  mem_ctrl_t mctl;

  logic key_nz, hit, ins, fill0, fill1, evict;

  assign accept = start && !busy;

  // Bucket index from the key.
  twhsc_bucket #(
    .CLUSTERS (CLUSTERS)
  ) u_bucket (
    .clk_i    (clk_i),
    .load_i   (accept),
    .key_i    (key_i),
    .bucket_o (bucket)
  );

  // Slot memories.
  assign mem_addr = (state_q == ST_SWEEP) ? sweep_q : bucket;

  twhsc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CLUSTERS)
  ) u_first (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mctl.we_first),
    .wdata_i (mctl.wipe ? '0 : key_q),
    .rdata_o (s0)
  );

  twhsc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CLUSTERS)
  ) u_second (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mctl.we_second),
    .wdata_i (mctl.wipe ? '0 : key_q),
    .rdata_o (s1)
  );

  // Bucket evaluation on the read data.
  always_comb begin
    key_nz = (key_q != '0);
    hit    = key_nz && ((s0 == key_q) || (s1 == key_q));
    ins    = (cmd_q == CMD_INSERT) && key_nz && !hit;
    fill0  = ins && (s0 == '0);
    fill1  = ins && (s0 != '0) && (s1 == '0);
    evict  = ins && (s0 != '0) && (s1 != '0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (command_i == CMD_CLEAR) ? ST_SWEEP : ST_HASH;
        end
      end
      ST_HASH:  state_d = ST_READ;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_IDLE;
      ST_SWEEP: begin
        if (sweep_q == LAST_A) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller: memory writes, counters and the result.
  always_comb begin
    mctl      = '0;
    sweep_d   = sweep_q;
    report_d  = report_q;
    occ_d     = occ_q;
    evc_d     = evc_q;
    done_d    = 1'b0;
    present_d = present_q;
    stored_d  = stored_q;
    evicted_d = evicted_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_CLEAR)) begin
          sweep_d  = '0;
          report_d = 1'b1;
          occ_d    = '0;
          evc_d    = '0;
        end
      end
      ST_HASH, ST_READ: begin
      end
      ST_EVAL: begin
        mctl.we_first  = fill0;
        mctl.we_second = fill1 || evict;
        if ((fill0 || fill1) && (occ_q != OCC_MAX)) begin
          occ_d = occ_q + 1'b1;
        end
        if (evict && (evc_q != EVICT_MAX)) begin
          evc_d = evc_q + 1'b1;
        end
        done_d    = 1'b1;
        present_d = hit;
        stored_d  = ins;
        evicted_d = evict;
      end
      ST_SWEEP: begin
        mctl.we_first  = 1'b1;
        mctl.we_second = 1'b1;
        mctl.wipe      = 1'b1;
        sweep_d        = sweep_q + 1'b1;
        if (sweep_q == LAST_A) begin
          done_d    = report_q;
          report_d  = 1'b0;
          present_d = 1'b0;
          stored_d  = 1'b0;
          evicted_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers; reset starts the wiping pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      sweep_q  <= '0;
      report_q <= 1'b0;
      occ_q    <= '0;
      evc_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      report_q <= report_d;
      occ_q    <= occ_d;
      evc_q    <= evc_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i;
    end
    present_q <= present_d;
    stored_q  <= stored_d;
    evicted_q <= evicted_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign present_o        = present_q;
  assign stored_o         = stored_q;
  assign evicted_o        = evicted_q;
  assign occupied_total_o = occ_q;
  assign eviction_total_o = evc_q;

  // Checks on the controller.
  `TWHSC_ASSERT(a_evict_is_store, clk_i, rst_ni, done_o && evicted_o |-> stored_o, "eviction without store")
  `TWHSC_ASSERT(a_single_beat, clk_i, rst_ni, done_o |=> !done_o, "result strobe held twice")
  `TWHSC_ASSERT(a_busy_after_take, clk_i, rst_ni, accept |=> busy, "not busy after taking a beat")
  `TWHSC_NEVER(a_hit_no_store, clk_i, rst_ni, done_o && present_o && stored_o, "stored a present key")

endmodule

[test/two_way_hash_set_cache_test.sv]
`timescale 1ns / 1ps

module two_way_hash_set_cache_test;
  import twhsc_pkg::*;

  localparam int unsigned CLUSTERS = CLUSTERS_DEF;
  localparam logic [2*KEY_W-1:0] CLUSTERS_WIDE = (2*KEY_W)'(CLUSTERS);
  // A clear sweeps every bucket, so the quiet spell can be that long.
  localparam int unsigned QUIET_LIMIT = 3 * (CLUSTERS + 16);
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 580;

  // One result as the block reports it.
  typedef struct packed {
    logic               present;
    logic               stored;
    logic               evicted;
    logic [OCC_W-1:0]   occupied;
    logic [EVICT_W-1:0] evictions;
  } probe_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   command_i;
  logic [KEY_W-1:0]   key_i;
  logic               done_o;
  logic               present_o;
  logic               stored_o;
  logic               evicted_o;
  logic [OCC_W-1:0]   occupied_total_o;
  logic [EVICT_W-1:0] eviction_total_o;

  // Shadow copy of the table and its counters.
  logic [KEY_W-1:0]   first_way [CLUSTERS];
  logic [KEY_W-1:0]   second_way [CLUSTERS];
  logic [OCC_W-1:0]   shadow_occupied;
  logic [EVICT_W-1:0] shadow_evictions;

  probe_result_t pending_results[$];

  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned lookups_sent, inserts_sent, clears_sent, reserved_sent;
  int unsigned results_checked, hits_seen, evictions_seen, peak_occupied;

  // Hot buckets and key tails for the random traffic, so that keys collide.
  logic [KEY_W-1:0] hot_buckets [6];
  logic [KEY_W-1:0] hot_tails [4];

  two_way_hash_set_cache #(
    .CLUSTERS(CLUSTERS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .key_i           (key_i),
    .done_o          (done_o),
    .present_o       (present_o),
    .stored_o        (stored_o),
    .evicted_o       (evicted_o),
    .occupied_total_o(occupied_total_o),
    .eviction_total_o(eviction_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bucket of a key: the upper half of the product of key and bucket count.
  function automatic int unsigned bucket_index(input logic [KEY_W-1:0] key);
    logic [2*KEY_W-1:0] product;
    product = {{KEY_W{1'b0}}, key} * CLUSTERS_WIDE;
    if (product[2*KEY_W-1:KEY_W] >= CLUSTERS_WIDE[KEY_W-1:0]) begin
      return CLUSTERS - 1;
    end
    return product[KEY_W+31:KEY_W];
  endfunction

  // Empty every slot and zero both counters.
  function automatic void wipe_table();
    for (int i = 0; i < CLUSTERS; i++) begin
      first_way[i]  = '0;
      second_way[i] = '0;
    end
    shadow_occupied  = '0;
    shadow_evictions = '0;
  endfunction

  // Apply one accepted beat to the shadow table and queue the result it owes.
  task automatic predict_probe(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
    probe_result_t    res;
    int unsigned      b;
    logic [KEY_W-1:0] s0;
    logic [KEY_W-1:0] s1;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      clears_sent++;
      wipe_table();
    end else begin
      if (cmd == CMD_INSERT) begin
        inserts_sent++;
      end else if (cmd == CMD_RSVD) begin
        reserved_sent++;
      end else begin
        lookups_sent++;
      end
      // A zero key matches nothing and changes nothing.
      if (key != '0) begin
        b  = bucket_index(key);
        s0 = first_way[b];
        s1 = second_way[b];
        res.present = (s0 == key) || (s1 == key);
        if (cmd == CMD_INSERT && !res.present) begin
          res.stored = 1'b1;
          if (s0 == '0) begin
            first_way[b] = key;
            if (shadow_occupied != OCC_MAX) shadow_occupied++;
          end else if (s1 == '0) begin
            second_way[b] = key;
            if (shadow_occupied != OCC_MAX) shadow_occupied++;
          end else begin
            second_way[b] = key;
            res.evicted = 1'b1;
            if (shadow_evictions != EVICT_MAX) shadow_evictions++;
          end
        end
      end
    end
    res.occupied  = shadow_occupied;
    res.evictions = shadow_evictions;
    pending_results.push_back(res);
  endtask

  // Send one beat and wait until the block takes it; then maybe pause.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
    int unsigned gap;
    start     <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_probe(cmd, key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // End of a burst: drop start and put junk on the payload while idle.
      gap = $urandom_range(1, 9);
      start     <= 1'b0;
      command_i <= 2'($urandom);
      key_i     <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        burst_left = $urandom_range(0, 8);
      end
    end
  endtask

  // Compare one field of a result.
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Check every result beat against the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    probe_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("present", 64'(want.present), 64'(present_o));
        check_field("stored", 64'(want.stored), 64'(stored_o));
        check_field("evicted", 64'(want.evicted), 64'(evicted_o));
        check_field("occupied_total", 64'(want.occupied), 64'(occupied_total_o));
        check_field("eviction_total", 64'(want.evictions), 64'(eviction_total_o));
        results_checked++;
        if (want.present) hits_seen++;
        if (want.evicted) evictions_seen++;
        if (32'(want.occupied) > peak_occupied) peak_occupied = 32'(want.occupied);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("two_way_hash_set_cache_test NOT OK");
      $finish;
    end
  end

  // Lookups into the empty table at both ends of the key range.
  task automatic test_empty_lookups();
    send_beat(CMD_LOOKUP, 64'h0000_0000_0000_0001);
    send_beat(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Fill both slots of the lowest bucket, force an eviction of slot two, then fill the highest bucket.
  task automatic test_fill_and_evict();
    send_beat(CMD_INSERT, 64'h0000_0000_0000_0001);
    send_beat(CMD_INSERT, 64'h000F_FFFF_FFFF_FFFF);
    send_beat(CMD_INSERT, 64'h0000_0000_0000_0002);
    send_beat(CMD_LOOKUP, 64'h0000_0000_0000_0001);
    send_beat(CMD_LOOKUP, 64'h000F_FFFF_FFFF_FFFF);
    send_beat(CMD_LOOKUP, 64'h0000_0000_0000_0002);
    send_beat(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_INSERT, 64'hFFF0_0000_0000_0000);
  endtask

  // Inserting a key that is already held changes nothing.
  task automatic test_duplicate_insert();
    send_beat(CMD_INSERT, 64'h0000_0000_0000_0001);
    send_beat(CMD_INSERT, 64'h0000_0000_0000_0002);
    send_beat(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // A zero key can never match and is never stored.
  task automatic test_zero_key();
    send_beat(CMD_LOOKUP, 64'h0);
    send_beat(CMD_INSERT, 64'h0);
  endtask

  // The unused command code behaves as a lookup.
  task automatic test_reserved_command();
    send_beat(CMD_RSVD, 64'h0000_0000_0000_0001);
    send_beat(CMD_RSVD, 64'h5555_5555_5555_5555);
    send_beat(CMD_LOOKUP, 64'h5555_5555_5555_5555);
  endtask

  // Clear empties the table and zeroes both counters whatever the key.
  task automatic test_clear();
    send_beat(CMD_CLEAR, 64'hA5A5_A5A5_A5A5_A5A5);
    send_beat(CMD_LOOKUP, 64'h0000_0000_0000_0001);
    send_beat(CMD_INSERT, 64'h0000_0000_0000_0001);
    send_beat(CMD_CLEAR, 64'h0);
  endtask

  // Key for random traffic: mostly hot keys that collide, some wild ones.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 18) return {$urandom, $urandom};
    return (hot_buckets[$urandom_range(0, 5)] << (KEY_W - 12)) | hot_tails[$urandom_range(0, 3)];
  endfunction

  // Random mix of lookups, inserts and reserved commands, mostly over a few hot buckets, with rare clears.
  task automatic test_random_traffic();
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    hot_buckets[0] = '0;
    hot_buckets[1] = KEY_W'(CLUSTERS - 1);
    for (int i = 2; i < 6; i++) hot_buckets[i] = KEY_W'($urandom_range(0, CLUSTERS - 1));
    hot_tails[0] = 64'h000F_FFFF_FFFF_FFFF;
    hot_tails[1] = 64'h1;
    for (int i = 2; i < 4; i++) hot_tails[i] = {$urandom, $urandom} & 64'h000F_FFFF_FFFF_FFFF;
    repeat (RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        cmd = CMD_CLEAR;
      end else if (r < 5) begin
        cmd = CMD_RSVD;
      end else if (r < 52) begin
        cmd = CMD_INSERT;
      end else begin
        cmd = CMD_LOOKUP;
      end
      send_beat(cmd, pick_key());
    end
  endtask

  initial begin
    fail_count  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    wipe_table();
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    command_i <= CMD_LOOKUP;
    key_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookups();
    test_fill_and_evict();
    test_duplicate_insert();
    test_zero_key();
    test_reserved_command();
    test_clear();
    test_random_traffic();
    start <= 1'b0;

    // Let the last results drain, then let the block idle before the summary.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d lookups, %0d inserts, %0d clears and %0d reserved commands.",
             lookups_sent, inserts_sent, clears_sent, reserved_sent);
    $display("Checked %0d results: %0d hits, %0d evictions, peak occupancy %0d.",
             results_checked, hits_seen, evictions_seen, peak_occupied);
    if (fail_count == 0) begin
      $display("two_way_hash_set_cache_test OK");
    end else begin
      $display("two_way_hash_set_cache_test NOT OK");
    end
    $finish;
  end

endmodule

[two_way_hash_set_cache.f]
+incdir+rtl/core
rtl/core/twhsc_pkg.sv
rtl/core/twhsc_ram.sv
rtl/core/twhsc_bucket.sv
rtl/core/two_way_hash_set_cache.sv
test/two_way_hash_set_cache_test.sv
